// ===== hdl/crt_pkg.sv =====
// Shared types and constants for the chunk reassembly tracker.
package crt_pkg;

    // Header field widths
    localparam int TAG_W   = 32;
    localparam int IDX_W   = 16;
    localparam int TOTAL_W = 9;
    localparam int CODEC_W = 32;
    localparam int BYTES_W = 19;
    localparam int TIME_W  = 64;

    // Result field widths
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 18;
    localparam int LENGTH_W = 11;

    // Keyframe bit within the header flags
    localparam logic KEY_MASK = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT  = 2'd0,
        ST_IGNORE  = 2'd1,
        ST_NO_SLOT = 2'd2
    } t_status;

    // Payload placement for one accepted chunk
    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
    } t_span;

endpackage

// ===== hdl/chunk_reassembly_tracker_unit.sv =====
// Top level of the chunk reassembly tracker: slot table, lookup and result register.
//
// Usage: one chunk header enters per beat on the input channel (i_valid / o_stall),
// one result leaves per beat on the output channel (o_valid / i_stall). Every
// header gives exactly one result, in order.
// Order: a header taken into the input register is looked up and applied to the
// slot table as its result is loaded into the result register for the outputs;
// a stall on the result channel holds the header in the input register.
// Throughput: one header per cycle while the result channel does not stall. The
// slot table is held in flip-flops, so the tag search, the bitmap test and the
// slot update are combinational; the next header already sees the updated table.
// Reset (i_rst_n low at a clock edge): all slots become free, received counts go
// to zero, both stages empty. No clearing pass is needed; the bitmap of a slot is
// cleared when a frame claims it.
// Stall: while i_stall holds a result, it stays unchanged on the outputs. One more
// header can wait in the input register; after that o_stall rises until the
// result is taken.
// Status: accepted chunk, ignored (duplicate, out of range or zero-count frame),
// or no free slot for a new frame. frame_done carries the stored frame metadata.
module chunk_reassembly_tracker_unit
    import crt_pkg::*;
#(
    parameter int SLOTS       = 8,
    parameter int MAX_CHUNKS  = 256,
    parameter int CHUNK_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Header channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [TAG_W-1:0]    i_frame_tag,
    input  logic [IDX_W-1:0]    i_chunk_index,
    input  logic [TOTAL_W-1:0]  i_chunk_total,
    input  logic [CODEC_W-1:0]  i_codec_tag,
    input  logic                i_keyframe_flag,
    input  logic [BYTES_W-1:0]  i_total_bytes,
    input  logic [TIME_W-1:0]   i_time_stamp,

    // Result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [OFFSET_W-1:0] o_write_offset,
    output logic [LENGTH_W-1:0] o_write_length,
    output logic                o_frame_done,
    output logic [TAG_W-1:0]    o_done_frame_tag,
    output logic [CODEC_W-1:0]  o_done_codec_tag,
    output logic                o_done_keyframe,
    output logic [TIME_W-1:0]   o_done_time_stamp,
    output logic [BYTES_W-1:0]  o_done_bytes
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAP_IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    // Slot table
    logic                  r_slot_valid [SLOTS];
    logic [TAG_W-1:0]      r_slot_tag   [SLOTS];
    logic [TOTAL_W-1:0]    r_slot_exp   [SLOTS];
    logic [TOTAL_W-1:0]    r_slot_recv  [SLOTS];
    logic [MAX_CHUNKS-1:0] r_slot_map   [SLOTS];
    logic [CODEC_W-1:0]    r_slot_codec [SLOTS];
    logic                  r_slot_key   [SLOTS];
    logic [TIME_W-1:0]     r_slot_time  [SLOTS];
    logic [BYTES_W-1:0]    r_slot_bytes [SLOTS];

    // Input register
    logic                  r_in_valid;
    logic [TAG_W-1:0]      r_in_tag;
    logic [IDX_W-1:0]      r_in_idx;
    logic [TOTAL_W-1:0]    r_in_total;
    logic [CODEC_W-1:0]    r_in_codec;
    logic                  r_in_key;
    logic [BYTES_W-1:0]    r_in_bytes;
    logic [TIME_W-1:0]     r_in_time;

    // Result register
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [OFFSET_W-1:0]   r_out_offset;
    logic [LENGTH_W-1:0]   r_out_length;
    logic                  r_out_done;
    logic [TAG_W-1:0]      r_out_tag;
    logic [CODEC_W-1:0]    r_out_codec;
    logic                  r_out_key;
    logic [TIME_W-1:0]     r_out_time;
    logic [BYTES_W-1:0]    r_out_bytes;

    // Next values of the result register
    t_status               n_out_status;
    logic [OFFSET_W-1:0]   n_out_offset;
    logic [LENGTH_W-1:0]   n_out_length;
    logic                  n_out_done;
    logic [TAG_W-1:0]      n_out_tag;
    logic [CODEC_W-1:0]    n_out_codec;
    logic                  n_out_key;
    logic [TIME_W-1:0]     n_out_time;
    logic [BYTES_W-1:0]    n_out_bytes;
    logic [TOTAL_W-1:0]    n_slot_recv;
    logic [MAX_CHUNKS-1:0] n_slot_map;

    // Lookup and update terms
    logic                  advance;
    logic                  load_in;
    logic                  hit;
    logic [SLOT_W-1:0]     hit_slot;
    logic                  free_any;
    logic [SLOT_W-1:0]     free_slot;
    logic [SLOT_W-1:0]     sel;
    logic                  no_slot;
    logic                  setup;
    logic                  table_wr;
    logic [TOTAL_W-1:0]    sat_total;
    logic [TOTAL_W-1:0]    eff_exp;
    logic [TOTAL_W-1:0]    eff_recv;
    logic [BYTES_W-1:0]    eff_bytes;
    logic [MAX_CHUNKS-1:0] eff_map;
    logic [MAP_IW-1:0]     map_idx;
    logic                  in_range;
    logic                  accept;
    logic                  done;
    t_span                 span;

    // Handshake: the input register moves on when the result register frees up
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign load_in = !o_stall;

    // Tag search and free-slot search, lowest slot wins
    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        free_any  = 1'b0;
        free_slot = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (r_slot_valid[k] && (r_slot_tag[k] == r_in_tag)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(k);
            end
            if (!r_slot_valid[k]) begin
                free_any  = 1'b1;
                free_slot = SLOT_W'(k);
            end
        end
    end

    // Slot selection and the view of the slot after a possible setup
    always_comb begin
        sel       = hit ? hit_slot : free_slot;
        no_slot   = !hit && !free_any;
        setup     = !hit || (r_slot_recv[sel] == '0);
        sat_total = (32'(r_in_total) > MAX_CHUNKS) ? TOTAL_W'(MAX_CHUNKS) : r_in_total;
        eff_exp   = setup ? sat_total  : r_slot_exp[sel];
        eff_recv  = setup ? '0         : r_slot_recv[sel];
        eff_bytes = setup ? r_in_bytes : r_slot_bytes[sel];
        eff_map   = setup ? '0         : r_slot_map[sel];
        map_idx   = r_in_idx[MAP_IW-1:0];
        in_range  = 32'(r_in_idx) < 32'(eff_exp);
        accept    = in_range && !eff_map[map_idx];
        n_slot_recv = eff_recv + TOTAL_W'(accept);
        done      = (n_slot_recv == eff_exp);
        n_slot_map = eff_map;
        if (accept) begin
            n_slot_map[map_idx] = 1'b1;
        end
        table_wr  = r_in_valid && advance && !no_slot;
    end

    crt_chunk_span #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_span (
        .i_chunk_index (r_in_idx),
        .i_frame_bytes (eff_bytes),
        .o_span        (span)
    );

    // Result fields; everything but the status is zero unless it applies
    always_comb begin
        n_out_status = ST_IGNORE;
        n_out_offset = '0;
        n_out_length = '0;
        n_out_done   = 1'b0;
        n_out_tag    = '0;
        n_out_codec  = '0;
        n_out_key    = 1'b0;
        n_out_time   = '0;
        n_out_bytes  = '0;
        if (no_slot) begin
            n_out_status = ST_NO_SLOT;
        end else begin
            if (accept) begin
                n_out_status = ST_ACCEPT;
                n_out_offset = span.offset;
                n_out_length = span.length;
            end
            if (done) begin
                n_out_done  = 1'b1;
                n_out_tag   = r_in_tag;
                n_out_codec = setup ? r_in_codec : r_slot_codec[sel];
                n_out_key   = (setup ? r_in_key : r_slot_key[sel]) & KEY_MASK;
                n_out_time  = setup ? r_in_time : r_slot_time[sel];
                n_out_bytes = eff_bytes;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_valid;
        end
        if (load_in && i_valid) begin
            r_in_tag   <= i_frame_tag;
            r_in_idx   <= i_chunk_index;
            r_in_total <= i_chunk_total;
            r_in_codec <= i_codec_tag;
            r_in_key   <= i_keyframe_flag;
            r_in_bytes <= i_total_bytes;
            r_in_time  <= i_time_stamp;
        end
    end

    // Slot table control: valid bits and received counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_slot_valid[k] <= 1'b0;
                r_slot_recv[k]  <= '0;
            end
        end else if (table_wr) begin
            r_slot_valid[sel] <= !done;
            r_slot_recv[sel]  <= done ? '0 : n_slot_recv;
        end
    end

    // Slot table payload: metadata on setup, bitmap on every update
    always_ff @(posedge i_clk) begin
        if (table_wr) begin
            r_slot_map[sel] <= n_slot_map;
            if (setup) begin
                r_slot_tag[sel]   <= r_in_tag;
                r_slot_exp[sel]   <= sat_total;
                r_slot_codec[sel] <= r_in_codec;
                r_slot_key[sel]   <= r_in_key & KEY_MASK;
                r_slot_time[sel]  <= r_in_time;
                r_slot_bytes[sel] <= r_in_bytes;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out_status <= n_out_status;
            r_out_offset <= n_out_offset;
            r_out_length <= n_out_length;
            r_out_done   <= n_out_done;
            r_out_tag    <= n_out_tag;
            r_out_codec  <= n_out_codec;
            r_out_key    <= n_out_key;
            r_out_time   <= n_out_time;
            r_out_bytes  <= n_out_bytes;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out_status;
    assign o_write_offset    = r_out_offset;
    assign o_write_length    = r_out_length;
    assign o_frame_done      = r_out_done;
    assign o_done_frame_tag  = r_out_tag;
    assign o_done_codec_tag  = r_out_codec;
    assign o_done_keyframe   = r_out_key;
    assign o_done_time_stamp = r_out_time;
    assign o_done_bytes      = r_out_bytes;

    // Checks
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("input stalled with an empty input register");

    a_done_frees_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (table_wr && done) |=> !r_slot_valid[$past(sel)])
        else $error("completed frame left its slot valid");

    a_no_slot_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NO_SLOT)) |-> (!o_frame_done && (o_write_length == '0)))
        else $error("dropped frame carries result data");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ACCEPT)) |->
            (32'(o_write_length) <= CHUNK_BYTES))
        else $error("write length exceeds one chunk");

endmodule

// ===== hdl/crt_chunk_span.sv =====
// Byte offset and clipped length of one chunk within its frame.
module crt_chunk_span
    import crt_pkg::*;
#(
    parameter int CHUNK_BYTES = 1024
) (
    input  logic [IDX_W-1:0]   i_chunk_index,
    input  logic [BYTES_W-1:0] i_frame_bytes,
    output t_span              o_span
);

    localparam int CB_W  = $clog2(CHUNK_BYTES + 1);
    localparam int OFF_W = IDX_W + CB_W;

    logic [OFF_W-1:0] offset;
    logic [OFF_W-1:0] bytes_ext;
    logic [OFF_W-1:0] remain;
    logic [OFF_W-1:0] length;

    // offset = index * chunk size, bytes left clipped to one chunk
    always_comb begin
        offset    = OFF_W'(i_chunk_index) * OFF_W'(CHUNK_BYTES);
        bytes_ext = OFF_W'(i_frame_bytes);
        remain    = (bytes_ext > offset) ? (bytes_ext - offset) : '0;
        length    = (remain < OFF_W'(CHUNK_BYTES)) ? remain : OFF_W'(CHUNK_BYTES);
        o_span.offset = offset[OFFSET_W-1:0];
        o_span.length = length[LENGTH_W-1:0];
    end

endmodule
